>>> rtl/mlft_pkg.sv
// Shared types and constants for the MAC learning forward table.
// Used by every module of the block; depends on nothing.
package mlft_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int PORT_BITS_DEF     = 4;
  localparam int MAC_BITS          = 48;
  localparam int ETYPE_BITS        = 16;
  localparam int AGE_BITS          = 8;
  localparam int VERDICT_BITS      = 2;
  localparam int CFG_IDX_BITS      = 8;
  localparam int CFG_DATA_BITS     = 16;
  localparam int QUEUE_DEPTH       = 2;
  localparam int CTRL_PORT         = 1;
  localparam int OP_BITS           = 2;
  localparam int CMD_FIXED_BITS    = OP_BITS + 2 * MAC_BITS;

  localparam logic [ETYPE_BITS-1:0] DATA_TYPE_RST   = 16'd0;
  localparam logic [ETYPE_BITS-1:0] CTRL_TYPE_RST   = 16'd1;
  localparam logic [AGE_BITS-1:0]   AGE_RELOAD_RST  = 8'd10;
  localparam logic [AGE_BITS-1:0]   EXPIRE_RST      = 8'd0;

  typedef enum logic [VERDICT_BITS-1:0] {
    VERDICT_BCAST = 2'd0,
    VERDICT_FWD   = 2'd1,
    VERDICT_DROP  = 2'd2
  } verdict_t;

  typedef enum logic [OP_BITS-1:0] {
    OP_BCAST = 2'd0,
    OP_DATA  = 2'd1,
    OP_AGE   = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DATA_TYPE  = 8'd0,
    CFG_CTRL_TYPE  = 8'd1,
    CFG_AGE_RELOAD = 8'd2,
    CFG_EXPIRE     = 8'd3
  } cfg_idx_t;

  typedef enum logic {
    ST_EXEC   = 1'b0,
    ST_LOOKUP = 1'b1
  } back_state_t;

  typedef struct packed {
    logic [ETYPE_BITS-1:0] data_type;
    logic [ETYPE_BITS-1:0] ctrl_type;
    logic [AGE_BITS-1:0]   age_reload;
    logic [AGE_BITS-1:0]   expire;
  } cfg_t;

endpackage

>>> rtl/mlft_front.sv
// Front end: takes header beats and classifies them into table commands.
// Depends on mlft_pkg; feeds mlft_queue.
module mlft_front #(
  parameter int PORT_BITS = mlft_pkg::PORT_BITS_DEF
) (
  input  logic                                         in_valid,
  output logic                                         in_stall,
  input  logic [PORT_BITS-1:0]                         in_port,
  input  logic [mlft_pkg::ETYPE_BITS-1:0]              in_ether_type,
  input  logic [mlft_pkg::MAC_BITS-1:0]                in_src_mac,
  input  logic [mlft_pkg::MAC_BITS-1:0]                in_dst_mac,
  input  mlft_pkg::cfg_t                               cfg,
  input  logic                                         q_full,
  output logic                                         q_push,
  output logic [mlft_pkg::CMD_FIXED_BITS+PORT_BITS-1:0] q_wdata
);
  import mlft_pkg::*;

  typedef struct packed {
    op_t                  op;
    logic [PORT_BITS-1:0] port;
    logic [MAC_BITS-1:0]  src;
    logic [MAC_BITS-1:0]  dst;
  } cmd_t;

  localparam logic [PORT_BITS-1:0] CTRL = PORT_BITS'(CTRL_PORT);

  cmd_t cmd;
  logic on_ctrl;

  always_comb begin
    on_ctrl  = (in_port == CTRL);
    cmd.port = in_port;
    cmd.src  = in_src_mac;
    cmd.dst  = in_dst_mac;
    if (on_ctrl && in_ether_type == cfg.ctrl_type) begin
      cmd.op = OP_AGE;
    end else if (!on_ctrl && in_ether_type == cfg.data_type) begin
      cmd.op = OP_DATA;
    end else begin
      cmd.op = OP_BCAST;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_wdata  = cmd;

endmodule

>>> rtl/mlft_queue.sv
// Short command queue between front and back end.
// Depends on mlft_pkg for its depth.
module mlft_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] rdata
);
  import mlft_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    slot_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_BITS'(1);
  endfunction

  assign full      = (count_r == CNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/mlft_back.sv
// Back end: holds the MAC table, learns, ages and looks up, drives result beats.
// Depends on mlft_pkg; pops commands from mlft_queue.
module mlft_back #(
  parameter int TABLE_ENTRIES = mlft_pkg::TABLE_ENTRIES_DEF,
  parameter int PORT_BITS     = mlft_pkg::PORT_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  mlft_pkg::cfg_t                               cfg,
  input  logic                                         q_not_empty,
  input  logic [mlft_pkg::CMD_FIXED_BITS+PORT_BITS-1:0] q_rdata,
  output logic                                         q_pop,
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output logic [mlft_pkg::VERDICT_BITS-1:0]            out_verdict,
  output logic [PORT_BITS-1:0]                         out_port
);
  import mlft_pkg::*;

  typedef struct packed {
    op_t                  op;
    logic [PORT_BITS-1:0] port;
    logic [MAC_BITS-1:0]  src;
    logic [MAC_BITS-1:0]  dst;
  } cmd_t;

  cmd_t head;

  back_state_t state_r, state_nxt;

  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [AGE_BITS-1:0]      age_r   [TABLE_ENTRIES];
  logic [AGE_BITS-1:0]      age_nxt [TABLE_ENTRIES];
  logic [MAC_BITS-1:0]      mac_r   [TABLE_ENTRIES];
  logic [MAC_BITS-1:0]      mac_nxt [TABLE_ENTRIES];
  logic [PORT_BITS-1:0]     port_r  [TABLE_ENTRIES];
  logic [PORT_BITS-1:0]     port_nxt[TABLE_ENTRIES];
  logic [AGE_BITS-1:0]      age_dec [TABLE_ENTRIES];

  logic [PORT_BITS-1:0] cur_port_r, cur_port_nxt;
  logic [MAC_BITS-1:0]  cur_dst_r, cur_dst_nxt;

  logic                 out_valid_r, out_valid_nxt;
  verdict_t             verdict_r, verdict_nxt;
  logic [PORT_BITS-1:0] oport_r, oport_nxt;

  logic [TABLE_ENTRIES-1:0] src_hit, src_first, free_vec, free_first, dst_hit, dst_first;
  logic [PORT_BITS-1:0]     hit_port;
  logic                     res_free;

  assign head = cmd_t'(q_rdata);

  always_comb begin
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      src_hit[k] = valid_r[k] && (mac_r[k] == head.src);
      dst_hit[k] = valid_r[k] && (mac_r[k] == cur_dst_r);
      age_dec[k] = age_r[k] - AGE_BITS'(1);
    end
    free_vec   = ~valid_r;
    src_first  = src_hit & (~src_hit + TABLE_ENTRIES'(1));
    free_first = free_vec & (~free_vec + TABLE_ENTRIES'(1));
    dst_first  = dst_hit & (~dst_hit + TABLE_ENTRIES'(1));
    hit_port   = '0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (dst_first[k]) begin
        hit_port = hit_port | port_r[k];
      end
    end
  end

  assign res_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    q_pop         = 1'b0;
    valid_nxt     = valid_r;
    age_nxt       = age_r;
    mac_nxt       = mac_r;
    port_nxt      = port_r;
    cur_port_nxt  = cur_port_r;
    cur_dst_nxt   = cur_dst_r;
    out_valid_nxt = out_valid_r && out_stall;
    verdict_nxt   = verdict_r;
    oport_nxt     = oport_r;
    case (state_r)
      ST_EXEC: begin
        if (q_not_empty) begin
          case (head.op)
            OP_DATA: begin
              q_pop        = 1'b1;
              cur_port_nxt = head.port;
              cur_dst_nxt  = head.dst;
              state_nxt    = ST_LOOKUP;
              for (int k = 0; k < TABLE_ENTRIES; k++) begin
                if (|src_hit) begin
                  if (src_first[k]) begin
                    age_nxt[k] = cfg.age_reload;
                  end
                end else if (free_first[k]) begin
                  valid_nxt[k] = 1'b1;
                  mac_nxt[k]   = head.src;
                  port_nxt[k]  = head.port;
                  age_nxt[k]   = cfg.age_reload;
                end
              end
            end
            OP_AGE: begin
              if (res_free) begin
                q_pop         = 1'b1;
                out_valid_nxt = 1'b1;
                verdict_nxt   = VERDICT_DROP;
                oport_nxt     = '0;
                for (int k = 0; k < TABLE_ENTRIES; k++) begin
                  if (valid_r[k]) begin
                    age_nxt[k] = age_dec[k];
                    if (age_dec[k] == cfg.expire) begin
                      valid_nxt[k] = 1'b0;
                    end
                  end
                end
              end
            end
            default: begin
              if (res_free) begin
                q_pop         = 1'b1;
                out_valid_nxt = 1'b1;
                verdict_nxt   = VERDICT_BCAST;
                oport_nxt     = '0;
              end
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        if (res_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_EXEC;
          if (!(|dst_hit)) begin
            verdict_nxt = VERDICT_BCAST;
            oport_nxt   = '0;
          end else if (hit_port == cur_port_r) begin
            verdict_nxt = VERDICT_DROP;
            oport_nxt   = '0;
          end else begin
            verdict_nxt = VERDICT_FWD;
            oport_nxt   = hit_port;
          end
        end
      end
      default: begin
        state_nxt = ST_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXEC;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        age_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      age_r       <= age_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mac_r      <= mac_nxt;
    port_r     <= port_nxt;
    cur_port_r <= cur_port_nxt;
    cur_dst_r  <= cur_dst_nxt;
    verdict_r  <= verdict_nxt;
    oport_r    <= oport_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;
  assign out_port    = oport_r;

endmodule

>>> rtl/mac_learning_forward_table.sv
// Top level of the MAC learning forward table: configuration registers and wiring
// of front end, command queue and back end. Depends on mlft_pkg and the mlft modules.
//
// One header beat in gives one verdict beat out, in order. The front end classifies
// a header in the cycle it is taken and parks it in a two-deep command queue; the
// back end then executes an aging or broadcast command in its execute state, and
// handles a data frame in the execute state (learn the source) and then the lookup
// state (look up the destination), both steps being a parallel compare across all
// table entries. Other frames go through at one per cycle while the output does not
// stall; a data frame holds back the next command until its lookup has finished.
// The result sits in an output register, so the queue keeps filling while a result
// waits. Configuration writes are always taken (cfg_ready is tied high) and must
// only be issued while no frame is in flight.
module mac_learning_forward_table #(
  parameter int TABLE_ENTRIES = mlft_pkg::TABLE_ENTRIES_DEF,
  parameter int PORT_BITS     = mlft_pkg::PORT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [PORT_BITS-1:0]                 in_port,
  input  logic [mlft_pkg::ETYPE_BITS-1:0]      in_ether_type,
  input  logic [mlft_pkg::MAC_BITS-1:0]        in_src_mac,
  input  logic [mlft_pkg::MAC_BITS-1:0]        in_dst_mac,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mlft_pkg::VERDICT_BITS-1:0]    out_verdict,
  output logic [PORT_BITS-1:0]                 out_port,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mlft_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [mlft_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
  import mlft_pkg::*;

  localparam int CMD_BITS = CMD_FIXED_BITS + PORT_BITS;

  cfg_t cfg_r, cfg_nxt;

  logic                q_push, q_pop, q_full, q_not_empty;
  logic [CMD_BITS-1:0] q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DATA_TYPE:  cfg_nxt.data_type  = cfg_wdata;
        CFG_CTRL_TYPE:  cfg_nxt.ctrl_type  = cfg_wdata;
        CFG_AGE_RELOAD: cfg_nxt.age_reload = cfg_wdata[AGE_BITS-1:0];
        CFG_EXPIRE:     cfg_nxt.expire     = cfg_wdata[AGE_BITS-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_type  <= DATA_TYPE_RST;
      cfg_r.ctrl_type  <= CTRL_TYPE_RST;
      cfg_r.age_reload <= AGE_RELOAD_RST;
      cfg_r.expire     <= EXPIRE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mlft_front #(
    .PORT_BITS(PORT_BITS)
  ) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_port      (in_port),
    .in_ether_type(in_ether_type),
    .in_src_mac   (in_src_mac),
    .in_dst_mac   (in_dst_mac),
    .cfg          (cfg_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  mlft_queue #(
    .WIDTH(CMD_BITS)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .rdata    (q_rdata)
  );

  mlft_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .PORT_BITS    (PORT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_not_empty(q_not_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_verdict(out_verdict),
    .out_port   (out_port)
  );

endmodule

>>> rtl/mlft_checker.sv
// Port-level checks for the MAC learning forward table, bound to the top level.
// Depends on mlft_pkg.
module mlft_checker #(
  parameter int PORT_BITS = mlft_pkg::PORT_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [mlft_pkg::VERDICT_BITS-1:0] out_verdict,
  input logic [PORT_BITS-1:0]              out_port
);
  import mlft_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_verdict) && $stable(out_port))
    else $error("result beat changed while stalled");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict == VERDICT_BCAST || out_verdict == VERDICT_FWD ||
                   out_verdict == VERDICT_DROP))
    else $error("result beat carries an unknown verdict");

  a_port_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict != VERDICT_FWD |-> out_port == '0)
    else $error("egress port set on a non-forward verdict");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_reset_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind mac_learning_forward_table mlft_checker #(
  .PORT_BITS(PORT_BITS)
) u_mlft_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_verdict(out_verdict),
  .out_port   (out_port)
);

>>> bench/tb_top.sv
// Testbench for mac_learning_forward_table: drives frame headers and register writes,
// predicts each verdict from a learning table with aging, and checks every result beat.
// Depends on mlft_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_top;
  import mlft_pkg::*;

  localparam int POOL = 24;

  typedef struct {
    verdict_t              verdict;
    logic [PORT_BITS_DEF-1:0] port;
  } verdict_beat_t;

  class forward_table_sb;
    logic [ETYPE_BITS-1:0]    data_code;
    logic [ETYPE_BITS-1:0]    ctrl_code;
    logic [AGE_BITS-1:0]      age_reload;
    logic [AGE_BITS-1:0]      expire;
    bit                       entry_valid [TABLE_ENTRIES_DEF];
    logic [MAC_BITS-1:0]      entry_mac   [TABLE_ENTRIES_DEF];
    logic [PORT_BITS_DEF-1:0] entry_port  [TABLE_ENTRIES_DEF];
    logic [AGE_BITS-1:0]      entry_age   [TABLE_ENTRIES_DEF];
    verdict_beat_t            verdicts_due [$];
    int n_fail, n_headers, n_fwd, n_drop, n_bcast, n_aging, n_expired, n_lost, n_settings;

    function new();
      data_code  = DATA_TYPE_RST;
      ctrl_code  = CTRL_TYPE_RST;
      age_reload = AGE_RELOAD_RST;
      expire     = EXPIRE_RST;
      foreach (entry_valid[k]) begin
        entry_valid[k] = 1'b0;
        entry_mac[k]   = '0;
        entry_port[k]  = '0;
        entry_age[k]   = '0;
      end
      n_fail = 0; n_headers = 0; n_fwd = 0; n_drop = 0; n_bcast = 0;
      n_aging = 0; n_expired = 0; n_lost = 0; n_settings = 0;
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        CFG_DATA_TYPE:  data_code  = val;
        CFG_CTRL_TYPE:  ctrl_code  = val;
        CFG_AGE_RELOAD: age_reload = val[AGE_BITS-1:0];
        CFG_EXPIRE:     expire     = val[AGE_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void note_header(logic [PORT_BITS_DEF-1:0] p, logic [ETYPE_BITS-1:0] et,
                              logic [MAC_BITS-1:0] src, logic [MAC_BITS-1:0] dst);
      verdict_beat_t exp_beat;
      bit done;
      exp_beat.verdict = VERDICT_BCAST;
      exp_beat.port    = '0;
      n_headers++;
      if (p == CTRL_PORT && et == ctrl_code) begin
        n_aging++;
        for (int k = 0; k < TABLE_ENTRIES_DEF; k++) begin
          if (entry_valid[k]) begin
            entry_age[k] = entry_age[k] - 1'b1;
            if (entry_age[k] == expire) begin
              entry_valid[k] = 1'b0;
              n_expired++;
            end
          end
        end
        exp_beat.verdict = VERDICT_DROP;
      end else if (p != CTRL_PORT && et == data_code) begin
        done = 1'b0;
        for (int k = 0; k < TABLE_ENTRIES_DEF && !done; k++) begin
          if (entry_valid[k] && entry_mac[k] == src) begin
            entry_age[k] = age_reload;
            done = 1'b1;
          end
        end
        for (int k = 0; k < TABLE_ENTRIES_DEF && !done; k++) begin
          if (!entry_valid[k]) begin
            entry_mac[k]   = src;
            entry_port[k]  = p;
            entry_age[k]   = age_reload;
            entry_valid[k] = 1'b1;
            done = 1'b1;
          end
        end
        if (!done) n_lost++;
        done = 1'b0;
        for (int k = 0; k < TABLE_ENTRIES_DEF && !done; k++) begin
          if (entry_valid[k] && entry_mac[k] == dst) begin
            done = 1'b1;
            if (entry_port[k] == p) begin
              exp_beat.verdict = VERDICT_DROP;
            end else begin
              exp_beat.verdict = VERDICT_FWD;
              exp_beat.port    = entry_port[k];
            end
          end
        end
      end
      case (exp_beat.verdict)
        VERDICT_FWD:  n_fwd++;
        VERDICT_DROP: n_drop++;
        default:      n_bcast++;
      endcase
      verdicts_due.push_back(exp_beat);
    endfunction

    function void check_verdict(logic [VERDICT_BITS-1:0] v, logic [PORT_BITS_DEF-1:0] p);
      verdict_beat_t exp_beat;
      if (verdicts_due.size() == 0) begin
        $error("result beat with no verdict expected: verdict %0d, out_port %0d", v, p);
        n_fail++;
        return;
      end
      exp_beat = verdicts_due.pop_front();
      if (v !== exp_beat.verdict) begin
        $error("verdict: expected %0d, actual %0d", exp_beat.verdict, v);
        n_fail++;
      end
      if (p !== exp_beat.port) begin
        $error("out_port: expected %0d, actual %0d", exp_beat.port, p);
        n_fail++;
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [PORT_BITS_DEF-1:0]    in_port = '0;
  logic [ETYPE_BITS-1:0]       in_ether_type = '0;
  logic [MAC_BITS-1:0]         in_src_mac = '0;
  logic [MAC_BITS-1:0]         in_dst_mac = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [VERDICT_BITS-1:0]     out_verdict;
  logic [PORT_BITS_DEF-1:0]    out_port;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_BITS-1:0]     cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]    cfg_wdata = '0;

  forward_table_sb sb = new();

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  logic [MAC_BITS-1:0]      mac_pool  [POOL];
  logic [PORT_BITS_DEF-1:0] home_port [POOL];

  mac_learning_forward_table u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_port       (in_port),
    .in_ether_type (in_ether_type),
    .in_src_mac    (in_src_mac),
    .in_dst_mac    (in_dst_mac),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_verdict   (out_verdict),
    .out_port      (out_port),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // check result beats; hold off on request, else stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_verdict(out_verdict, out_port);
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 64;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic logic [MAC_BITS-1:0] rand_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[MAC_BITS-1:0];
  endfunction

  function automatic logic [PORT_BITS_DEF-1:0] any_data_port();
    logic [PORT_BITS_DEF-1:0] p;
    p = PORT_BITS_DEF'($urandom_range(0, 14));
    if (p >= CTRL_PORT) p++;
    return p;
  endfunction

  task automatic send_header(logic [PORT_BITS_DEF-1:0] p, logic [ETYPE_BITS-1:0] et,
                             logic [MAC_BITS-1:0] src, logic [MAC_BITS-1:0] dst);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_port       <= p;
    in_ether_type <= et;
    in_src_mac    <= src;
    in_dst_mac    <= dst;
    do @(posedge clk); while (in_stall);
    sb.note_header(p, et, src, dst);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic set_config(logic [ETYPE_BITS-1:0] data_code, logic [ETYPE_BITS-1:0] ctrl_code,
                            logic [AGE_BITS-1:0] reload, logic [AGE_BITS-1:0] expire);
    wait_drained();
    write_reg(CFG_DATA_TYPE, data_code);
    write_reg(CFG_CTRL_TYPE, ctrl_code);
    write_reg(CFG_AGE_RELOAD, {8'd0, reload});
    write_reg(CFG_EXPIRE, {8'd0, expire});
    cfg_valid <= 1'b0;
    sb.n_settings++;
  endtask

  task automatic random_header();
    logic [PORT_BITS_DEF-1:0] p;
    logic [ETYPE_BITS-1:0]    et;
    logic [MAC_BITS-1:0]      src, dst;
    int kind, si, di;
    kind = $urandom_range(0, 99);
    si   = $urandom_range(0, POOL - 1);
    di   = $urandom_range(0, POOL - 1);
    src  = ($urandom_range(0, 9) != 0) ? mac_pool[si] : rand_mac();
    dst  = ($urandom_range(0, 4) != 0) ? mac_pool[di] : rand_mac();
    p    = ($urandom_range(0, 6) != 0) ? home_port[si] : any_data_port();
    et   = sb.data_code;
    if (kind < 12) begin
      p  = CTRL_PORT;
      et = sb.ctrl_code;
    end else if (kind < 18) begin
      p = CTRL_PORT;
    end else if (kind < 23) begin
      et = sb.ctrl_code;
    end else if (kind < 28) begin
      p  = PORT_BITS_DEF'($urandom_range(0, 15));
      et = ETYPE_BITS'($urandom_range(0, 65535));
    end
    send_header(p, et, src, dst);
  endtask

  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    logic [ETYPE_BITS-1:0] dcode;
    mac_pool[0] = '0;
    mac_pool[1] = '1;
    home_port[0] = any_data_port();
    home_port[1] = any_data_port();
    for (int k = 2; k < POOL; k++) begin
      mac_pool[k]  = rand_mac();
      home_port[k] = any_data_port();
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    set_config(16'h0800, 16'h88CC, 8'd3, 8'd0);
    send_header(4'd0,  16'h0800, mac_pool[0], mac_pool[1]);
    send_header(4'd15, 16'h0800, mac_pool[1], mac_pool[0]);
    send_header(4'd0,  16'h0800, mac_pool[0], mac_pool[1]);
    send_header(4'd7,  16'h0800, mac_pool[0], mac_pool[0]);
    send_header(4'd0,  16'h0800, mac_pool[0], mac_pool[0]);
    send_header(4'd1,  16'h0800, mac_pool[2], mac_pool[0]);
    send_header(4'd3,  16'h88CC, mac_pool[2], mac_pool[0]);
    send_header(4'd1,  16'h1234, mac_pool[2], mac_pool[0]);
    send_header(4'd1,  16'h88CC, mac_pool[2], mac_pool[3]);
    send_header(4'd5,  16'h0800, mac_pool[2], mac_pool[1]);
    send_header(4'd1,  16'h88CC, mac_pool[3], mac_pool[2]);
    send_header(4'd1,  16'h88CC, mac_pool[3], mac_pool[2]);
    send_header(4'd9,  16'h0800, mac_pool[3], mac_pool[0]);
    for (int k = 0; k < 14; k++) begin
      send_header(4'(k % 14 + 2), 16'h0800, 48'hA5A5_0000_0000 + 48'(k), mac_pool[2]);
    end
    send_header(4'd6, 16'h0800, 48'h5A5A_0000_0000, 48'h5A5A_0000_0000);

    for (int blk = 0; blk < 4; blk++) begin
      case (blk)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          set_config(16'h0800, 16'h88CC, 8'd4, 8'd0);
        end
        1: begin
          send_idle_pct = 54;
          stall_pct     = 0;
          set_config(16'hFFFF, 16'hFFFF, 8'd255, 8'd255);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 54;
          set_config(16'h0000, 16'hFFFF, 8'd0, 8'd254);
        end
        default: begin
          send_idle_pct = 15;
          stall_pct     = 15;
          dcode = ETYPE_BITS'($urandom_range(0, 65535));
          set_config(dcode, dcode ^ 16'($urandom_range(1, 65535)),
                     8'($urandom_range(1, 8)), 8'($urandom_range(0, 2)));
        end
      endcase
      for (int i = 0; i < 150; i++) begin
        if (blk == 0 && i == 0) hold_req = 1'b1;
        if (i == 75) wait_drained();
        random_header();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d headers under %0d register settings:",
             sb.n_headers, sb.n_settings);
    $display("%0d forwarded, %0d dropped, %0d flooded",
             sb.n_fwd, sb.n_drop, sb.n_bcast);
    $display("%0d aging frames expired %0d entries; %0d sources went unlearned on a full table",
             sb.n_aging, sb.n_expired, sb.n_lost);
    if (sb.n_fail == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/mlft_pkg.sv
rtl/mlft_front.sv
rtl/mlft_queue.sv
rtl/mlft_back.sv
rtl/mac_learning_forward_table.sv
rtl/mlft_checker.sv
bench/tb_top.sv
